// ----- rtl/core/kqf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kqf_pkg
// Shared types and constants of the Kuwahara quadrant filter.
// ----------------------------------------------------------------------------
package kqf_pkg;

    localparam int MAX_WINDOW  = 9;
    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 4096;
    localparam int STORE_DEPTH = MAX_WINDOW * MAX_WIDTH;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int ROW_W       = $clog2(MAX_HEIGHT);
    localparam int PIX_W       = 8;
    localparam int CFG_W       = 13;
    localparam int POS_W       = COL_W + ROW_W;
    localparam int RECIP_ROW   = 65536 / MAX_WINDOW;
    localparam int RECIP_N9    = 65536 / 9;
    localparam int RECIP_N25   = 65536 / 25;

    localparam logic [1:0] CFG_WINDOW_SIZE  = 2'd0;
    localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd2;

    typedef struct packed {
        logic             req_type;
        logic [PIX_W-1:0] pixel_in;
    } t_in_word;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             row_end;
        logic             frame_end;
    } t_out_word;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_WAIT,
        ST_DIV,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic       accept;
        logic       tap_valid;
        logic       tap_last;
        logic [1:0] quad;
        logic [2:0] tap_row;
        logic [2:0] tap_col;
        logic       div_start;
        logic       emit;
    } t_cmd;

    typedef struct packed {
        logic       emit_req;
        logic [2:0] span;
        logic       best_done;
        logic       out_free;
    } t_status;

endpackage

// ----- rtl/core/kqf_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kqf_ctrl
// Sequencer that walks the four subwindows and steps the datapath.
// ----------------------------------------------------------------------------
module kqf_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  kqf_pkg::t_status i_status,
    output kqf_pkg::t_cmd    o_cmd
);
    import kqf_pkg::*;

    t_state     r_state, n_state;
    logic [1:0] r_q;
    logic [2:0] r_i, r_j;
    logic       tap_last, walk_end;

    assign tap_last = (r_j == i_status.span) && (r_i == i_status.span);
    assign walk_end = tap_last && (r_q == 2'd3);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid && i_status.emit_req) n_state = ST_WALK;
            end
            ST_WALK: begin
                if (walk_end) n_state = ST_WAIT;
            end
            ST_WAIT: begin
                if (i_status.best_done) n_state = ST_DIV;
            end
            ST_DIV:  n_state = ST_EMIT;
            ST_EMIT: begin
                if (i_status.out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready      = (r_state == ST_IDLE);
        o_cmd.accept    = (r_state == ST_IDLE) && i_in_valid;
        o_cmd.tap_valid = (r_state == ST_WALK);
        o_cmd.tap_last  = tap_last;
        o_cmd.quad      = r_q;
        o_cmd.tap_row   = r_i;
        o_cmd.tap_col   = r_j;
        o_cmd.div_start = (r_state == ST_DIV);
        o_cmd.emit      = (r_state == ST_EMIT) && i_status.out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_q     <= '0;
            r_i     <= '0;
            r_j     <= '0;
        end else begin
            r_state <= n_state;
            if (r_state != ST_WALK) begin
                r_q <= '0;
                r_i <= '0;
                r_j <= '0;
            end else if (r_j == i_status.span) begin
                r_j <= '0;
                if (r_i == i_status.span) begin
                    r_i <= '0;
                    r_q <= r_q + 2'd1;
                end else begin
                    r_i <= r_i + 3'd1;
                end
            end else begin
                r_j <= r_j + 3'd1;
            end
        end
    end

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_status.best_done |-> r_state == ST_WAIT)
        else $error("subwindow result arrived outside the wait state");

    a_walk_leaves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK && walk_end) |=> r_state == ST_WAIT)
        else $error("walk did not end after the last tap");

    a_emit_leaves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |=> r_state == ST_IDLE)
        else $error("controller stayed busy after loading a word");

endmodule

// ----- rtl/core/kqf_dpath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kqf_dpath
// Line store, position counters, tap address pipeline, variance compare,
// mean divider and output register.
// ----------------------------------------------------------------------------
module kqf_dpath (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [1:0]              i_cfg_index,
    input  logic [kqf_pkg::CFG_W-1:0] i_cfg_data,
    input  kqf_pkg::t_in_word       i_in_data,
    input  logic                    i_out_ready,
    output logic                    o_out_valid,
    output kqf_pkg::t_out_word      o_out_data,
    input  kqf_pkg::t_cmd           i_cmd,
    output kqf_pkg::t_status        o_status
);
    import kqf_pkg::*;

    logic [3:0]        r_cfg_win;
    logic [10:0]       r_cfg_w;
    logic [12:0]       r_cfg_h;

    logic [COL_W-1:0]  r_in_col, r_out_col;
    logic [ROW_W-1:0]  r_in_row, r_out_row;
    logic [POS_W-1:0]  r_pos;
    logic [ADDR_W-1:0] r_wr_addr;
    logic              r_received;

    logic [PIX_W-1:0]  r_mem [STORE_DEPTH];

    logic              win_ok;
    logic [2:0]        span;
    logic [4:0]        n_val;
    logic [10:0]       eff_w;
    logic [12:0]       eff_h;
    logic [POS_W-1:0]  lag;
    logic              pix_item, restart, row_end, frame_end, cfg_hit;

    always_comb begin
        win_ok = (r_cfg_win[1:0] == 2'b01) && (r_cfg_win >= 4'd5)
                 && ({28'b0, r_cfg_win} <= MAX_WINDOW);
        span   = win_ok ? {r_cfg_win[3:2], 1'b0} : 3'd2;
        n_val  = 5'((span + 3'd1) * (span + 3'd1));
        if (r_cfg_w < 11'd5) eff_w = 11'd5;
        else if ({21'b0, r_cfg_w} > MAX_WIDTH) eff_w = 11'(MAX_WIDTH);
        else eff_w = r_cfg_w;
        if (r_cfg_h < 13'd5) eff_h = 13'd5;
        else if ({19'b0, r_cfg_h} > MAX_HEIGHT) eff_h = 13'(MAX_HEIGHT);
        else eff_h = r_cfg_h;
        lag      = POS_W'(span * eff_w) + POS_W'(span);
        pix_item = !i_in_data.req_type && !r_received;
        row_end  = ({1'b0, r_out_col} == eff_w - 11'd1);
        frame_end = row_end && ({1'b0, r_out_row} == eff_h - 13'd1);
        cfg_hit  = i_cfg_we && (i_cfg_index == CFG_WINDOW_SIZE
                   || i_cfg_index == CFG_IMAGE_WIDTH
                   || i_cfg_index == CFG_IMAGE_HEIGHT);
        restart  = cfg_hit || (i_cmd.emit && frame_end);
    end

    assign o_status.emit_req = pix_item ? (r_pos >= lag) : r_received;
    assign o_status.span     = span;
    assign o_status.out_free = !o_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_win <= 4'd5;
            r_cfg_w   <= 11'd640;
            r_cfg_h   <= 13'd480;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_WINDOW_SIZE:  r_cfg_win <= i_cfg_data[3:0];
                CFG_IMAGE_WIDTH:  r_cfg_w   <= i_cfg_data[10:0];
                CFG_IMAGE_HEIGHT: r_cfg_h   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col   <= '0;
            r_in_row   <= '0;
            r_out_col  <= '0;
            r_out_row  <= '0;
            r_pos      <= '0;
            r_wr_addr  <= '0;
            r_received <= 1'b0;
        end else if (restart) begin
            r_in_col   <= '0;
            r_in_row   <= '0;
            r_out_col  <= '0;
            r_out_row  <= '0;
            r_pos      <= '0;
            r_wr_addr  <= '0;
            r_received <= 1'b0;
        end else begin
            if (i_cmd.accept && pix_item) begin
                r_pos     <= r_pos + POS_W'(1);
                r_wr_addr <= ({18'b0, r_wr_addr} == STORE_DEPTH - 1) ? '0
                             : r_wr_addr + ADDR_W'(1);
                if ({1'b0, r_in_col} + 11'd1 >= eff_w) begin
                    r_in_col <= '0;
                    if ({1'b0, r_in_row} + 13'd1 >= eff_h) begin
                        r_in_row   <= '0;
                        r_received <= 1'b1;
                    end else begin
                        r_in_row <= r_in_row + ROW_W'(1);
                    end
                end else begin
                    r_in_col <= r_in_col + COL_W'(1);
                end
            end
            if (i_cmd.emit) begin
                if (row_end) begin
                    r_out_col <= '0;
                    r_out_row <= r_out_row + ROW_W'(1);
                end else begin
                    r_out_col <= r_out_col + COL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && pix_item) begin
            r_mem[r_wr_addr] <= i_in_data.pixel_in;
        end
    end

    logic signed [12:0] c_s, wm1;
    logic signed [14:0] r_s, hm1;
    logic [COL_W-1:0]   m_col;
    logic [ROW_W-1:0]   m_row;

    always_comb begin
        c_s = $signed({3'b000, r_out_col}) + $signed({10'b0, i_cmd.tap_col})
              - $signed({10'b0, (i_cmd.quad[0] ? 3'd0 : span)});
        wm1 = $signed({2'b00, eff_w}) - 13'sd1;
        if (c_s < 0) c_s = -c_s;
        if (c_s > wm1) c_s = (wm1 <<< 1) - c_s;
        m_col = c_s[COL_W-1:0];
        r_s = $signed({3'b000, r_out_row}) + $signed({12'b0, i_cmd.tap_row})
              - $signed({12'b0, (i_cmd.quad[1] ? 3'd0 : span)});
        hm1 = $signed({2'b00, eff_h}) - 15'sd1;
        if (r_s < 0) r_s = -r_s;
        if (r_s > hm1) r_s = (hm1 <<< 1) - r_s;
        m_row = r_s[ROW_W-1:0];
    end

    logic [COL_W-1:0]  r1_col, r2_col;
    logic [ROW_W-1:0]  r1_row;
    logic [POS_W-1:0]  r2_prod;
    logic [ROW_W-1:0]  r3_hi;
    logic [COL_W-1:0]  r3_lo;
    logic [8:0]        r3_qest;
    logic [ADDR_W-1:0] r4_addr;
    logic [PIX_W-1:0]  r5_pix;
    logic [5:1]        r_v, r_l;

    logic [POS_W-1:0]  lin;
    logic [24:0]       qprod;
    logic [12:0]       q9, rem13;
    logic [4:0]        rem5;

    always_comb begin
        lin   = r2_prod + POS_W'(r2_col);
        qprod = 25'(lin[POS_W-1:COL_W]) * 25'(RECIP_ROW);
        q9    = 13'(r3_qest) * 13'(MAX_WINDOW);
        rem13 = 13'(r3_hi) - q9;
        rem5  = rem13[4:0];
        if (rem5 >= 5'(MAX_WINDOW)) rem5 = rem5 - 5'(MAX_WINDOW);
    end

    always_ff @(posedge i_clk) begin
        r1_col  <= m_col;
        r1_row  <= m_row;
        r2_prod <= POS_W'(r1_row * eff_w);
        r2_col  <= r1_col;
        r3_hi   <= lin[POS_W-1:COL_W];
        r3_lo   <= lin[COL_W-1:0];
        r3_qest <= qprod[24:16];
        r4_addr <= {rem5[ADDR_W-COL_W-1:0], r3_lo};
        r5_pix  <= r_mem[r4_addr];
        r_l     <= {r_l[4:1], i_cmd.tap_last};
    end

    logic [12:0] r_acc_sum, r6_sum, r7_sum, r_best_sum;
    logic [20:0] r_acc_sq, r6_sq;
    logic [25:0] r7_nsq, r7_s2, r_best_var, var_cur;
    logic        r6_valid, r7_valid, r_best_done;
    logic [1:0]  r_qcnt;
    logic [12:0] acc_sum_n;
    logic [20:0] acc_sq_n;

    always_comb begin
        acc_sum_n = r_acc_sum + 13'(r5_pix);
        acc_sq_n  = r_acc_sq + 21'(r5_pix * r5_pix);
        var_cur   = r7_nsq - r7_s2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v         <= '0;
            r6_valid    <= 1'b0;
            r7_valid    <= 1'b0;
            r_best_done <= 1'b0;
            r_qcnt      <= '0;
            r_acc_sum   <= '0;
            r_acc_sq    <= '0;
        end else begin
            r_v         <= {r_v[4:1], i_cmd.tap_valid};
            r6_valid    <= r_v[5] && r_l[5];
            r7_valid    <= r6_valid;
            r_best_done <= r7_valid && (r_qcnt == 2'd3);
            if (r7_valid) r_qcnt <= r_qcnt + 2'd1;
            if (r_v[5]) begin
                r_acc_sum <= r_l[5] ? '0 : acc_sum_n;
                r_acc_sq  <= r_l[5] ? '0 : acc_sq_n;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r6_sum <= acc_sum_n;
        r6_sq  <= acc_sq_n;
        r7_nsq <= 26'(r6_sq * n_val);
        r7_s2  <= 26'(r6_sum * r6_sum);
        r7_sum <= r6_sum;
        if (r7_valid && (r_qcnt == 2'd0 || var_cur < r_best_var)) begin
            r_best_var <= var_cur;
            r_best_sum <= r7_sum;
        end
    end

    assign o_status.best_done = r_best_done;

    logic [12:0] r_dx, qn, drem;
    logic [25:0] r_dprod;
    logic [9:0]  q0, quot;

    always_comb begin
        q0   = r_dprod[25:16];
        qn   = 13'(q0 * n_val);
        drem = r_dx - qn;
        quot = (drem >= 13'(n_val)) ? q0 + 10'd1 : q0;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_dx    <= r_best_sum + 13'(n_val >> 1);
            r_dprod <= 26'((r_best_sum + 13'(n_val >> 1))
                       * ((span == 3'd4) ? 13'(RECIP_N25) : 13'(RECIP_N9)));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_out_data.pixel_out <= quot[PIX_W-1:0];
            o_out_data.row_end   <= row_end;
            o_out_data.frame_end <= frame_end;
        end
    end

    a_addr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[4] |-> {18'b0, r4_addr} < STORE_DEPTH)
        else $error("tap address beyond the line store");

    a_div_fix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> drem < 13'(2 * n_val))
        else $error("mean quotient estimate off by more than one");

    a_quad_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r6_valid |=> r7_valid)
        else $error("subwindow sums lost before the compare");

endmodule

// ----- rtl/core/kuwahara_quadrant_filter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kuwahara_quadrant_filter
// Kuwahara filter over a raster stream of 8-bit pixels.
// ----------------------------------------------------------------------------
// The input channel takes one word per pixel in raster order, or a drain
// word once the whole frame is in. The output channel gives one filtered
// pixel with row and frame end flags. Output lags input by R*W+R pixels,
// R being half the window; drain words flush the last ones.
// A word that yields no result is taken and the input stays ready. A word
// that yields a result holds the input until its result is loaded into the
// output register, with one tap a cycle over each 9 or 25 pixel subwindow
// through the line store read port and the shared multiply-accumulate.
// The next word is taken while a result still waits in the output register;
// a stalled receiver holds the block only once a second result is ready.
// Reset restores the register defaults and restarts the frame. The line
// store is not cleared. Register writes restart the frame as well.
// ----------------------------------------------------------------------------
module kuwahara_quadrant_filter (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [1:0]                i_cfg_index,
    input  logic [kqf_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  kqf_pkg::t_in_word         i_in_data,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output kqf_pkg::t_out_word        o_out_data
);
    import kqf_pkg::*;

    t_cmd    cmd;
    t_status status;

    kqf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    kqf_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_cmd       (cmd),
        .o_status    (status)
    );

endmodule
